/* design/pixel_row_bit_packer_unit_assert.svh */
// Assertion macros for the pixel row bit packer, included by prbp_pack.
`ifndef PIXEL_ROW_BIT_PACKER_UNIT_ASSERT_SVH
`define PIXEL_ROW_BIT_PACKER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PRBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("packer assertion failed");

// Next-cycle implication, checked outside reset.
`define PRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("packer assertion failed");

`endif

/* design/prbp_pkg.sv */
// Package: types, constants and helpers for the pixel row bit packer.
`timescale 1ns / 1ps
package prbp_pkg;

    localparam int DEF_MAX_ROW_WIDTH = 4096;
    localparam int ROW_WIDTH_W       = 13;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd1;

    localparam logic [1:0] MODE_1BPP  = 2'd0;
    localparam logic [1:0] MODE_GRAY2 = 2'd1;
    localparam logic [1:0] MODE_RGB332 = 2'd2;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd8;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
    } t_out_item;

    function automatic logic [1:0] gray_code(input logic [7:0] r);
        logic [1:0] code;
        unique case (r)
            8'd0:    code = 2'd3;
            8'd128:  code = 2'd2;
            8'd192:  code = 2'd1;
            default: code = 2'd0;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] rgb332(input t_in_item p);
        return {p.red[7:5], p.green[7:5], p.blue[7:6]};
    endfunction

endpackage

/* design/prbp_cfg.sv */
// Configuration registers: pixel mode and clamped row width.
`timescale 1ns / 1ps
module prbp_cfg
    import prbp_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
    parameter int CNT_W         = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [1:0]            o_mode,
    output logic [CNT_W-1:0]      o_eff_width,
    output logic                  o_clear
);

    localparam int EFF_MAX = (MAX_ROW_WIDTH < 8191) ? MAX_ROW_WIDTH : 8191;
    localparam logic [ROW_WIDTH_W-1:0] EFF_MAX_W = ROW_WIDTH_W'(EFF_MAX);

    logic [1:0]             r_mode;
    logic [CNT_W-1:0]       r_eff_width;
    logic [ROW_WIDTH_W-1:0] w_raw;
    logic [ROW_WIDTH_W-1:0] w_eff;

    always_comb begin
        w_raw = i_cfg_data[ROW_WIDTH_W-1:0];
        if (w_raw == '0) begin
            w_eff = ROW_WIDTH_W'(1);
        end else if (w_raw > EFF_MAX_W) begin
            w_eff = EFF_MAX_W;
        end else begin
            w_eff = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_1BPP;
            r_eff_width <= CNT_W'(ROW_WIDTH_RESET);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PIXEL_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else if (i_cfg_index == CFG_ROW_WIDTH) begin
                r_eff_width <= CNT_W'(w_eff);
            end
        end
    end

    assign o_mode      = r_mode;
    assign o_eff_width = r_eff_width;
    assign o_clear     = i_cfg_valid &&
                         (i_cfg_index == CFG_PIXEL_MODE || i_cfg_index == CFG_ROW_WIDTH);

endmodule

/* design/prbp_pack.sv */
// Input register and byte packing state for the pixel row bit packer.
`timescale 1ns / 1ps
module prbp_pack
    import prbp_pkg::*;
#(
    parameter int CNT_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    input  logic [1:0]       i_mode,
    input  logic [CNT_W-1:0] i_eff_width,
    input  logic             i_clear,
    input  logic             i_slot_free,
    output logic             o_res_valid,
    output t_out_item        o_res_data
);

    `include "pixel_row_bit_packer_unit_assert.svh"

    logic             r_in_valid;
    t_in_item         r_pix;
    logic [7:0]       r_acc;
    logic [2:0]       r_pib;
    logic [CNT_W-1:0] r_col;

    logic             proc;
    logic [7:0]       acc_upd;
    logic [3:0]       n_pib;
    logic [CNT_W-1:0] n_col;
    logic             full;
    logic             last;
    logic             emit;

    assign proc       = r_in_valid && i_slot_free;
    assign o_in_ready = !r_in_valid || proc;

    always_comb begin
        n_pib = {1'b0, r_pib} + 4'd1;
        n_col = r_col + CNT_W'(1);
        last  = n_col >= i_eff_width;
        unique case (i_mode)
            MODE_1BPP: begin
                acc_upd = r_acc | ((r_pix.red == 8'd0) ? (8'h80 >> r_pib) : 8'h00);
                full    = n_pib == 4'd8;
            end
            MODE_GRAY2: begin
                acc_upd = r_acc | ({6'b0, gray_code(r_pix.red)} << {~r_pib[1:0], 1'b0});
                full    = n_pib == 4'd4;
            end
            default: begin
                acc_upd = rgb332(r_pix);
                full    = 1'b1;
            end
        endcase
        emit = full || last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pix <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc <= '0;
            r_pib <= '0;
            r_col <= '0;
        end else if (proc) begin
            if (emit) begin
                r_acc <= '0;
                r_pib <= '0;
                r_col <= last ? '0 : n_col;
            end else begin
                r_acc <= acc_upd;
                r_pib <= n_pib[2:0];
                r_col <= n_col;
            end
        end
    end

    assign o_res_valid            = proc && emit;
    assign o_res_data.packed_byte = acc_upd;
    assign o_res_data.row_end     = last;

    `PRBP_ASSERT_SAME(a_col_in_row, i_clk, i_rst_n, 1'b1, r_col < i_eff_width)
    `PRBP_ASSERT_SAME(a_gray_pib, i_clk, i_rst_n, i_mode == MODE_GRAY2, r_pib < 3'd4)
    `PRBP_ASSERT_NEXT(a_row_restart, i_clk, i_rst_n, proc && last, r_col == '0 && r_pib == '0)
    `PRBP_ASSERT_SAME(a_res_needs_slot, i_clk, i_rst_n, o_res_valid, i_slot_free && r_in_valid)

endmodule

/* design/prbp_out_reg.sv */
// Output register holding one packed byte until the receiver takes it.
`timescale 1ns / 1ps
module prbp_out_reg
    import prbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res_data,
    output logic      o_slot_free,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_slot_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_slot_free && i_res_valid) begin
            r_data <= i_res_data;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

/* design/pixel_row_bit_packer_unit.sv */
// Usage:
// Pixel input channel (i_in_valid / o_in_ready, i_in_data): one RGB pixel per
//   transaction, in raster order.
// Result channel (o_out_valid / i_out_ready, o_out_data): one packed byte per
//   transaction with a row_end flag on the last byte of each row.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): index 0
//   is the pixel mode, index 1 the row width. A valid write to index 0 or 1 restarts
//   the row and drops gathered pixels; write only while the block is idle.
// Throughput: one pixel per cycle while the receiver takes bytes, set by the single
//   packing stage between the input register and the output register.
// Path: the pixel that completes a byte is held in the input register, and the
//   byte is then registered in the output register that drives o_out_valid.
// Reset: mode 1 bpp, row width 8, empty byte, column 0, both registers empty.
// Receiver stall: the output register holds the byte; the input register
//   holds one more pixel, after which o_in_ready drops until the byte is taken.
`timescale 1ns / 1ps
module pixel_row_bit_packer_unit
    import prbp_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EFF_MAX = (MAX_ROW_WIDTH < 8191) ? MAX_ROW_WIDTH : 8191;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);

    logic [1:0]       mode;
    logic [CNT_W-1:0] eff_width;
    logic             clear;
    logic             slot_free;
    logic             res_valid;
    t_out_item        res_data;

    assign o_cfg_ready = 1'b1;

    prbp_cfg #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .CNT_W         (CNT_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mode      (mode),
        .o_eff_width (eff_width),
        .o_clear     (clear)
    );

    prbp_pack #(
        .CNT_W (CNT_W)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_mode      (mode),
        .i_eff_width (eff_width),
        .i_clear     (clear),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res_data  (res_data)
    );

    prbp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_data  (res_data),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
